FILE: rtl/core/tra_pkg.sv
package tra_pkg;

    // Opcode bytes of the instruction set.
    localparam logic [7:0] OP_LDI_A  = 8'h20;
    localparam logic [7:0] OP_LDI_B  = 8'h21;
    localparam logic [7:0] OP_LDI_C  = 8'h22;
    localparam logic [7:0] OP_MOV_AA = 8'h23;
    localparam logic [7:0] OP_MOV_AB = 8'h24;
    localparam logic [7:0] OP_MOV_AC = 8'h25;
    localparam logic [7:0] OP_MOV_BA = 8'h26;
    localparam logic [7:0] OP_MOV_BB = 8'h27;
    localparam logic [7:0] OP_MOV_BC = 8'h28;
    localparam logic [7:0] OP_MOV_CA = 8'h29;
    localparam logic [7:0] OP_MOV_CB = 8'h2A;
    localparam logic [7:0] OP_MOV_CC = 8'h2B;
    localparam logic [7:0] OP_CMP_C  = 8'h40;
    localparam logic [7:0] OP_XOR_C  = 8'h41;
    localparam logic [7:0] OP_ADD_C  = 8'h60;
    localparam logic [7:0] OP_ADD_A  = 8'h61;
    localparam logic [7:0] OP_ADD_B  = 8'h62;
    localparam logic [7:0] OP_SUB_C  = 8'h63;
    localparam logic [7:0] OP_SUB_A  = 8'h64;
    localparam logic [7:0] OP_SUB_B  = 8'h65;
    localparam logic [7:0] OP_DIV_C  = 8'h66;
    localparam logic [7:0] OP_DIV_A  = 8'h67;
    localparam logic [7:0] OP_DIV_B  = 8'h68;
    localparam logic [7:0] OP_MUL_C  = 8'h69;
    localparam logic [7:0] OP_MUL_A  = 8'h6A;
    localparam logic [7:0] OP_MUL_B  = 8'h6B;

    // Width of the result value ports.
    localparam int unsigned OUT_BITS = 8;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_LOAD,
        ALU_MOVE,
        ALU_CMPEQ,
        ALU_XOR,
        ALU_ADD,
        ALU_SUB,
        ALU_DIV,
        ALU_MUL
    } t_alu_op;

    typedef enum logic [1:0] {
        REG_A,
        REG_B,
        REG_C
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_alu_op op;
        t_reg    dst;
        t_reg    src;
    } t_decode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    exec;
        logic    div_start;
        logic    div_write;
        logic    set_fault;
        logic    publish;
        t_alu_op op;
        t_reg    dst;
        t_reg    src;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic b_zero;
        logic div_done;
    } t_dp_status;

endpackage

FILE: rtl/core/tra_div.sv
module tra_div
    import tra_pkg::*;
#(
    parameter int unsigned WORD_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_dividend,
    input  logic [WORD_BITS-1:0] i_divisor,
    output logic [WORD_BITS-1:0] o_quotient,
    output logic                 o_done
);

    localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] r_quo;
    logic [WORD_BITS-1:0] n_quo;
    logic [WORD_BITS-1:0] r_den;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [WORD_BITS-1:0] w_abs_num;
    logic [WORD_BITS-1:0] w_abs_den;
    logic [WORD_BITS:0]   w_shift;
    logic [WORD_BITS:0]   w_diff;

    // Magnitudes of the signed operands; the most negative value maps to itself.
    assign w_abs_num = i_dividend[WORD_BITS-1] ? (~i_dividend + WORD_BITS'(1)) : i_dividend;
    assign w_abs_den = i_divisor[WORD_BITS-1] ? (~i_divisor + WORD_BITS'(1)) : i_divisor;

    // One restoring step per cycle: shift in the next dividend bit and try a subtract.
    // The partial remainder stays below the divisor magnitude, so it fits in WORD_BITS.
    always_comb begin
        w_shift = {r_rem, r_quo[WORD_BITS-1]};
        w_diff  = w_shift - {1'b0, r_den};
        if (w_shift >= {1'b0, r_den}) begin
            n_rem = w_diff[WORD_BITS-1:0];
            n_quo = {r_quo[WORD_BITS-2:0], 1'b1};
        end else begin
            n_rem = w_shift[WORD_BITS-1:0];
            n_quo = {r_quo[WORD_BITS-2:0], 1'b0};
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WORD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_abs_num;
            r_den <= w_abs_den;
            r_neg <= i_dividend[WORD_BITS-1] ^ i_divisor[WORD_BITS-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // The quotient truncates toward zero, so only its sign needs fixing.
    assign o_quotient = r_neg ? (~r_quo + WORD_BITS'(1)) : r_quo;
    assign o_done     = r_done;

endmodule

FILE: rtl/core/tra_dp.sv
module tra_dp
    import tra_pkg::*;
#(
    parameter int unsigned WORD_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic [7:0]                 i_immediate,
    output logic signed [OUT_BITS-1:0] o_value_a,
    output logic signed [OUT_BITS-1:0] o_value_b,
    output logic signed [OUT_BITS-1:0] o_value_c,
    output logic                       o_divide_fault
);

    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_c;
    logic [WORD_BITS-1:0] n_a;
    logic [WORD_BITS-1:0] n_b;
    logic [WORD_BITS-1:0] n_c;
    logic                 r_fault;
    logic [7:0]           r_imm;
    logic [WORD_BITS-1:0] w_src;
    logic [WORD_BITS-1:0] w_prod;
    logic [WORD_BITS-1:0] w_alu;
    logic                 w_wr;
    logic [WORD_BITS-1:0] w_wr_data;
    logic [WORD_BITS-1:0] w_quo;
    logic                 w_div_done;
    logic [OUT_BITS-1:0]  r_out_a;
    logic [OUT_BITS-1:0]  r_out_b;
    logic [OUT_BITS-1:0]  r_out_c;
    logic                 r_out_fault;

    // Iterative divider for a / b.
    tra_div #(
        .WORD_BITS(WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // Source register for moves.
    always_comb begin
        case (i_cmd.src)
            REG_A:   w_src = r_a;
            REG_B:   w_src = r_b;
            REG_C:   w_src = r_c;
            default: w_src = r_a;
        endcase
    end

    assign w_prod = r_a * r_b;

    // Combinational ALU operations.
    always_comb begin
        case (i_cmd.op)
            ALU_LOAD:  w_alu = WORD_BITS'(r_imm);
            ALU_MOVE:  w_alu = w_src;
            ALU_CMPEQ: w_alu = WORD_BITS'(r_a == r_b);
            ALU_XOR:   w_alu = r_a ^ r_b;
            ALU_ADD:   w_alu = r_a + r_b;
            ALU_SUB:   w_alu = r_b - r_a;
            ALU_MUL:   w_alu = w_prod;
            default:   w_alu = '0;
        endcase
    end

    // Write-back selection; a no-op writes nothing.
    assign w_wr = i_cmd.div_write
               || (i_cmd.exec && (i_cmd.op != ALU_NONE) && (i_cmd.op != ALU_DIV));
    assign w_wr_data = i_cmd.div_write ? w_quo : w_alu;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        if (w_wr) begin
            case (i_cmd.dst)
                REG_A:   n_a = w_wr_data;
                REG_B:   n_b = w_wr_data;
                default: n_c = w_wr_data;
            endcase
        end
    end

    // Architectural registers and the fault flag of the current transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_fault <= 1'b0;
        end else begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            if (i_cmd.set_fault) begin
                r_fault <= 1'b1;
            end else if (i_cmd.exec || i_cmd.div_write) begin
                r_fault <= 1'b0;
            end
        end
    end

    // Immediate byte is held from acceptance until execution.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_imm <= i_immediate;
        end
    end

    // Output register keeps a finished result while the next transaction runs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_a     <= r_a[OUT_BITS-1:0];
            r_out_b     <= r_b[OUT_BITS-1:0];
            r_out_c     <= r_c[OUT_BITS-1:0];
            r_out_fault <= r_fault;
        end
    end

    assign o_status.b_zero   = (r_b == '0);
    assign o_status.div_done = w_div_done;

    assign o_value_a      = r_out_a;
    assign o_value_b      = r_out_b;
    assign o_value_c      = r_out_c;
    assign o_divide_fault = r_out_fault;

endmodule

FILE: rtl/core/tra_ctrl.sv
module tra_ctrl
    import tra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_operation,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state  r_state;
    t_state  n_state;
    t_decode r_dec;
    t_decode w_dec;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_accept;

    // Opcode decoder: operation class, destination and move source.
    always_comb begin
        w_dec = '{op: ALU_NONE, dst: REG_C, src: REG_A};
        unique case (i_operation)
            OP_LDI_A:  w_dec = '{op: ALU_LOAD,  dst: REG_A, src: REG_A};
            OP_LDI_B:  w_dec = '{op: ALU_LOAD,  dst: REG_B, src: REG_A};
            OP_LDI_C:  w_dec = '{op: ALU_LOAD,  dst: REG_C, src: REG_A};
            OP_MOV_AA: w_dec = '{op: ALU_MOVE,  dst: REG_A, src: REG_A};
            OP_MOV_AB: w_dec = '{op: ALU_MOVE,  dst: REG_A, src: REG_B};
            OP_MOV_AC: w_dec = '{op: ALU_MOVE,  dst: REG_A, src: REG_C};
            OP_MOV_BA: w_dec = '{op: ALU_MOVE,  dst: REG_B, src: REG_A};
            OP_MOV_BB: w_dec = '{op: ALU_MOVE,  dst: REG_B, src: REG_B};
            OP_MOV_BC: w_dec = '{op: ALU_MOVE,  dst: REG_B, src: REG_C};
            OP_MOV_CA: w_dec = '{op: ALU_MOVE,  dst: REG_C, src: REG_A};
            OP_MOV_CB: w_dec = '{op: ALU_MOVE,  dst: REG_C, src: REG_B};
            OP_MOV_CC: w_dec = '{op: ALU_MOVE,  dst: REG_C, src: REG_C};
            OP_CMP_C:  w_dec = '{op: ALU_CMPEQ, dst: REG_C, src: REG_A};
            OP_XOR_C:  w_dec = '{op: ALU_XOR,   dst: REG_C, src: REG_A};
            OP_ADD_C:  w_dec = '{op: ALU_ADD,   dst: REG_C, src: REG_A};
            OP_ADD_A:  w_dec = '{op: ALU_ADD,   dst: REG_A, src: REG_A};
            OP_ADD_B:  w_dec = '{op: ALU_ADD,   dst: REG_B, src: REG_A};
            OP_SUB_C:  w_dec = '{op: ALU_SUB,   dst: REG_C, src: REG_A};
            OP_SUB_A:  w_dec = '{op: ALU_SUB,   dst: REG_A, src: REG_A};
            OP_SUB_B:  w_dec = '{op: ALU_SUB,   dst: REG_B, src: REG_A};
            OP_DIV_C:  w_dec = '{op: ALU_DIV,   dst: REG_C, src: REG_A};
            OP_DIV_A:  w_dec = '{op: ALU_DIV,   dst: REG_A, src: REG_A};
            OP_DIV_B:  w_dec = '{op: ALU_DIV,   dst: REG_B, src: REG_A};
            OP_MUL_C:  w_dec = '{op: ALU_MUL,   dst: REG_C, src: REG_A};
            OP_MUL_A:  w_dec = '{op: ALU_MUL,   dst: REG_A, src: REG_A};
            OP_MUL_B:  w_dec = '{op: ALU_MUL,   dst: REG_B, src: REG_A};
            default:   w_dec = '{op: ALU_NONE,  dst: REG_C, src: REG_A};
        endcase
    end

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // State, decoded instruction and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dec <= w_dec;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state           = r_state;
        n_out_valid       = r_out_valid && !i_out_ready;
        o_cmd             = '0;
        o_cmd.op          = r_dec.op;
        o_cmd.dst         = r_dec.dst;
        o_cmd.src         = r_dec.src;
        o_cmd.capture     = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_dec.op == ALU_DIV) begin
                    if (i_status.b_zero) begin
                        o_cmd.set_fault = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_write = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/three_register_accumulator_core.sv
// An accepted transaction passes through the execute and done states, and its
// result is published and flagged valid once the output register is free.
// A divide by a nonzero value also runs the divider, which resolves one
// quotient bit per cycle, before the quotient is written back; a divide by
// zero skips the divider and sets the fault. A new transaction is taken while
// the previous result waits in the output register.
// Reset (synchronous, active low) clears registers a, b and c to zero and drops
// the result valid.
module three_register_accumulator_core
    import tra_pkg::*;
#(
    parameter int unsigned WORD_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_operation,
    input  logic [7:0]                 i_immediate,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_BITS-1:0] o_value_a,
    output logic signed [OUT_BITS-1:0] o_value_b,
    output logic signed [OUT_BITS-1:0] o_value_c,
    output logic                       o_divide_fault
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    tra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Register file, ALU, divider and output register.
    tra_dp #(
        .WORD_BITS(WORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_immediate    (i_immediate),
        .o_value_a      (o_value_a),
        .o_value_b      (o_value_b),
        .o_value_c      (o_value_c),
        .o_divide_fault (o_divide_fault)
    );

endmodule

FILE: rtl/core/tra_chk.sv
module tra_chk
    import tra_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [OUT_BITS-1:0] o_value_a,
    input logic signed [OUT_BITS-1:0] o_value_b,
    input logic signed [OUT_BITS-1:0] o_value_c,
    input logic                       o_divide_fault
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped before the transaction completed");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_value_a) && $stable(o_value_b)
            && $stable(o_value_c) && $stable(o_divide_fault))
        else $error("stalled result payload changed");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The core works on one transaction at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

endmodule

bind three_register_accumulator_core tra_chk u_chk (.*);
